// ===== rtl/hcbm_pkg.sv =====
`default_nettype none

package hcbm_pkg;

   // table size, one cell per slot
   localparam int TABLE_ENTRIES = 8;

   // code format
   localparam int MAX_DEPTH  = 8;
   localparam int DIGIT_BITS = 4;
   localparam int CODE_W     = 32;
   localparam int LEN_W      = 4;
   localparam int SLOT_W     = 3;
   localparam int FUNC_W     = 2;

   // transaction function codes
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_BEST  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_EXACT = 2'd2;

   // table write broadcast to every cell
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] index;
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } hcbm_write_type;

   // query token handed from cell to cell
   typedef struct packed {
      logic              exact;
      logic [LEN_W-1:0]  q_len;
      logic [CODE_W-1:0] q_code;
      logic              any;
      logic [SLOT_W-1:0] best_slot;
      logic [LEN_W-1:0]  best_len;
      logic [CODE_W-1:0] best_code;
      logic [LEN_W-1:0]  best_dist;
      logic              provided;
   } hcbm_token_type;

endpackage

`default_nettype wire

// ===== rtl/hcbm_cell.sv =====
`default_nettype none

module hcbm_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [hcbm_pkg::LEN_W-1:0] entry_count,
   input  wire hcbm_pkg::hcbm_write_type   wr,
   input  wire logic                       in_vld,
   input  wire hcbm_pkg::hcbm_token_type   in_tok,
   output logic                            out_vld,
   output hcbm_pkg::hcbm_token_type        out_tok
);

   localparam int CMP_W = 8;
   localparam logic [CMP_W-1:0] MY_INDEX = CMP_W'(CELL_INDEX);
   localparam int DB = hcbm_pkg::DIGIT_BITS;

   logic [hcbm_pkg::LEN_W-1:0]  len_ff;
   logic [hcbm_pkg::CODE_W-1:0] code_ff;
   logic                        vld_ff;
   hcbm_pkg::hcbm_token_type    tok_ff;
   hcbm_pkg::hcbm_token_type    tok_in;

   logic                        active;
   logic                        run;
   logic [hcbm_pkg::LEN_W-1:0]  min_len;
   logic [hcbm_pkg::LEN_W-1:0]  cp;
   logic [hcbm_pkg::LEN_W-1:0]  d_e;
   logic [hcbm_pkg::LEN_W-1:0]  d_q;
   logic [hcbm_pkg::LEN_W-1:0]  ent_dist;

   // entry is searched only when it lies below the count
   assign active = in_vld && ({{(CMP_W-hcbm_pkg::LEN_W){1'b0}}, entry_count} > MY_INDEX);

   // common prefix, then distance of the stored entry to the query
   always_comb begin
      min_len = (in_tok.q_len < len_ff) ? in_tok.q_len : len_ff;
      run     = 1'b1;
      cp      = '0;
      for (int i = 0; i < hcbm_pkg::MAX_DEPTH; i++) begin
         if (run && (hcbm_pkg::LEN_W'(i) < min_len) &&
             (in_tok.q_code[i*DB +: DB] == code_ff[i*DB +: DB])) begin
            cp = cp + hcbm_pkg::LEN_W'(1);
         end else begin
            run = 1'b0;
         end
      end
      d_e = len_ff - cp;
      d_q = in_tok.q_len - cp;
      if (len_ff == cp) begin
         ent_dist = '0;
      end else begin
         ent_dist = (d_e > d_q) ? d_e : d_q;
      end
   end

   // fold this entry into the running result
   always_comb begin
      tok_in = in_tok;
      if (active) begin
         if (in_tok.exact) begin
            if ((len_ff == in_tok.q_len) && (code_ff == in_tok.q_code)) begin
               tok_in.provided = 1'b1;
            end
         end else if (!in_tok.any || (ent_dist < in_tok.best_dist)) begin
            tok_in.any       = 1'b1;
            tok_in.best_slot = hcbm_pkg::SLOT_W'(CELL_INDEX);
            tok_in.best_len  = len_ff;
            tok_in.best_code = code_ff;
            tok_in.best_dist = ent_dist;
         end
      end
   end

   // stored entry
   always_ff @(posedge clock) begin
      if (wr.en && ({{(CMP_W-hcbm_pkg::SLOT_W){1'b0}}, wr.index} == MY_INDEX)) begin
         len_ff  <= wr.len;
         code_ff <= wr.code;
      end
   end

   // token stage toward the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
      tok_ff <= tok_in;
   end

   assign out_vld = vld_ff;
   assign out_tok = tok_ff;

endmodule

`default_nettype wire

// ===== rtl/hierarchical_code_best_match_core.sv =====
`default_nettype none

// Table of hierarchical service codes with best-match and exact-match lookup.
// Each table slot lives in one cell of a row of TABLE_ENTRIES cells; a query
// travels down the row one cell per cycle, collecting the first slot of least
// distance (or the exact-match flag) on the way. A write transaction updates
// its slot register and returns nothing. A query passes the injection register,
// each cell's register and the response register. One query is in the row at
// a time; the next transaction is taken once the previous response enters the
// response register, even while it waits on rsp_ready there. csr_entry_count
// sets how many slots are searched and must be written only while no query is
// outstanding; the block itself does not enforce this. Slots that are searched
// must have been written first.

module hierarchical_code_best_match_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // configuration
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [hcbm_pkg::LEN_W-1:0]  csr_entry_count,
   // request
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [hcbm_pkg::FUNC_W-1:0] req_func,
   input  wire logic [hcbm_pkg::SLOT_W-1:0] req_entry_index,
   input  wire logic [hcbm_pkg::LEN_W-1:0]  req_code_length,
   input  wire logic [hcbm_pkg::CODE_W-1:0] req_code_digits,
   // response
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_found,
   output logic [hcbm_pkg::SLOT_W-1:0]      rsp_best_slot,
   output logic [hcbm_pkg::LEN_W-1:0]       rsp_best_length,
   output logic [hcbm_pkg::CODE_W-1:0]      rsp_best_code,
   output logic [hcbm_pkg::LEN_W-1:0]       rsp_distance,
   output logic                             rsp_provided
);

   localparam int DB = hcbm_pkg::DIGIT_BITS;
   localparam int TABLE_ENTRIES = hcbm_pkg::TABLE_ENTRIES;

   logic [hcbm_pkg::LEN_W-1:0]  count_ff;
   logic                        busy_ff;
   logic                        busy_in;
   logic                        inj_vld_ff;
   logic                        inj_vld_in;
   hcbm_pkg::hcbm_token_type    inj_tok_ff;
   hcbm_pkg::hcbm_token_type    inj_tok_in;
   logic                        rsp_vld_ff;
   logic                        rsp_vld_in;
   hcbm_pkg::hcbm_token_type    rsp_tok_ff;
   hcbm_pkg::hcbm_token_type    rsp_tok_in;
   logic                        hold_vld_ff;
   logic                        hold_vld_in;
   hcbm_pkg::hcbm_token_type    hold_tok_ff;
   hcbm_pkg::hcbm_token_type    hold_tok_in;

   logic                        req_fire;
   logic                        is_query;
   logic                        rsp_fire;
   logic [hcbm_pkg::LEN_W-1:0]  q_len;
   logic [hcbm_pkg::CODE_W-1:0] q_code;
   hcbm_pkg::hcbm_write_type    wr;

   logic                        chain_vld [TABLE_ENTRIES+1];
   hcbm_pkg::hcbm_token_type    chain_tok [TABLE_ENTRIES+1];

   // handshakes
   assign csr_ready = 1'b1;
   assign req_ready = !busy_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_vld_ff && rsp_ready;

   always_comb begin
      unique case (req_func)
         hcbm_pkg::FUNC_BEST,
         hcbm_pkg::FUNC_EXACT: is_query = 1'b1;
         default:              is_query = 1'b0;
      endcase
   end

   // clamp the length and clear digits past it
   always_comb begin
      q_len = (req_code_length > hcbm_pkg::LEN_W'(hcbm_pkg::MAX_DEPTH)) ?
              hcbm_pkg::LEN_W'(hcbm_pkg::MAX_DEPTH) : req_code_length;
      q_code = '0;
      for (int i = 0; i < hcbm_pkg::MAX_DEPTH; i++) begin
         if (hcbm_pkg::LEN_W'(i) < q_len) begin
            q_code[i*DB +: DB] = req_code_digits[i*DB +: DB];
         end
      end
   end

   // table write broadcast
   assign wr.en    = req_fire && (req_func == hcbm_pkg::FUNC_WRITE);
   assign wr.index = req_entry_index;
   assign wr.len   = q_len;
   assign wr.code  = q_code;

   // fresh query token
   always_comb begin
      inj_vld_in           = req_fire && is_query;
      inj_tok_in.exact     = (req_func == hcbm_pkg::FUNC_EXACT);
      inj_tok_in.q_len     = q_len;
      inj_tok_in.q_code    = q_code;
      inj_tok_in.any       = 1'b0;
      inj_tok_in.best_slot = '0;
      inj_tok_in.best_len  = '0;
      inj_tok_in.best_code = '0;
      inj_tok_in.best_dist = inj_tok_in.exact ? '0 :
                             hcbm_pkg::LEN_W'(hcbm_pkg::MAX_DEPTH);
      inj_tok_in.provided  = 1'b0;
   end

   // row of cells
   assign chain_vld[0] = inj_vld_ff;
   assign chain_tok[0] = inj_tok_ff;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      hcbm_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .entry_count (count_ff),
         .wr          (wr),
         .in_vld      (chain_vld[g]),
         .in_tok      (chain_tok[g]),
         .out_vld     (chain_vld[g+1]),
         .out_tok     (chain_tok[g+1])
      );
   end

   // response register with one spare slot for a stalled response
   always_comb begin
      busy_in     = busy_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_tok_in  = rsp_tok_ff;
      hold_vld_in = hold_vld_ff;
      hold_tok_in = hold_tok_ff;
      if (rsp_fire) begin
         rsp_vld_in = 1'b0;
      end
      if (hold_vld_ff && rsp_fire) begin
         rsp_vld_in  = 1'b1;
         rsp_tok_in  = hold_tok_ff;
         hold_vld_in = 1'b0;
         busy_in     = 1'b0;
      end
      if (chain_vld[TABLE_ENTRIES]) begin
         if (!rsp_vld_ff || rsp_ready) begin
            rsp_vld_in = 1'b1;
            rsp_tok_in = chain_tok[TABLE_ENTRIES];
            busy_in    = 1'b0;
         end else begin
            hold_vld_in = 1'b1;
            hold_tok_in = chain_tok[TABLE_ENTRIES];
         end
      end
      if (req_fire && is_query) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         busy_ff     <= 1'b0;
         inj_vld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         hold_vld_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            count_ff <= csr_entry_count;
         end
         busy_ff     <= busy_in;
         inj_vld_ff  <= inj_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         hold_vld_ff <= hold_vld_in;
      end
      inj_tok_ff  <= inj_tok_in;
      rsp_tok_ff  <= rsp_tok_in;
      hold_tok_ff <= hold_tok_in;
   end

   // response fields
   assign rsp_valid       = rsp_vld_ff;
   assign rsp_found       = rsp_tok_ff.any;
   assign rsp_best_slot   = rsp_tok_ff.best_slot;
   assign rsp_best_length = rsp_tok_ff.best_len;
   assign rsp_best_code   = rsp_tok_ff.best_code;
   assign rsp_distance    = rsp_tok_ff.best_dist;
   assign rsp_provided    = rsp_tok_ff.provided;

   // checks
   a_hold_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      hold_vld_ff |-> rsp_vld_ff)
      else $error("spare response slot filled while response register empty");

   a_row_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      chain_vld[TABLE_ENTRIES] |-> busy_ff)
      else $error("query left the cell row while no query outstanding");

   a_query_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_query) |=> (busy_ff && inj_vld_ff))
      else $error("accepted query not injected into the cell row");

   a_empty_result_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_tok_ff.any) |-> (rsp_tok_ff.best_slot == '0))
      else $error("response without a match carries a slot");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SIZE = hcbm_pkg::TABLE_ENTRIES;
   localparam int LATENCY = TABLE_SIZE + 2;
   localparam int SETTLE_CYCLES = 2 * LATENCY;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD = 400;
   localparam int PHASE_ITEMS = 200;
   localparam int MAX_REPORTS = 40;
   localparam logic [hcbm_pkg::LEN_W-1:0] DEPTH_LEN =
      hcbm_pkg::LEN_W'(hcbm_pkg::MAX_DEPTH);
   // function code the block ignores
   localparam logic [hcbm_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // one response: found, slot, length, code, distance, provided
   typedef struct packed {
      logic                        found;
      logic [hcbm_pkg::SLOT_W-1:0] best_slot;
      logic [hcbm_pkg::LEN_W-1:0]  best_length;
      logic [hcbm_pkg::CODE_W-1:0] best_code;
      logic [hcbm_pkg::LEN_W-1:0]  distance;
      logic                        provided;
   } answer_type;

   // one stimulus step: a request, or an entry_count write
   typedef struct packed {
      logic                        is_csr;
      logic [hcbm_pkg::LEN_W-1:0]  csr_value;
      logic [hcbm_pkg::FUNC_W-1:0] func;
      logic [hcbm_pkg::SLOT_W-1:0] idx;
      logic [hcbm_pkg::LEN_W-1:0]  len;
      logic [hcbm_pkg::CODE_W-1:0] digits;
      logic                        typed;
      answer_type                  ans;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [hcbm_pkg::LEN_W-1:0] csr_entry_count = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [hcbm_pkg::FUNC_W-1:0] req_func = '0;
   logic [hcbm_pkg::SLOT_W-1:0] req_entry_index = '0;
   logic [hcbm_pkg::LEN_W-1:0] req_code_length = '0;
   logic [hcbm_pkg::CODE_W-1:0] req_code_digits = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_found;
   logic [hcbm_pkg::SLOT_W-1:0] rsp_best_slot;
   logic [hcbm_pkg::LEN_W-1:0] rsp_best_length;
   logic [hcbm_pkg::CODE_W-1:0] rsp_best_code;
   logic [hcbm_pkg::LEN_W-1:0] rsp_distance;
   logic rsp_provided;

   // shadow of the code table and the search limit
   logic [hcbm_pkg::LEN_W-1:0] slot_len [TABLE_SIZE];
   logic [hcbm_pkg::CODE_W-1:0] slot_code [TABLE_SIZE];
   logic [hcbm_pkg::LEN_W-1:0] entry_count_reg = '0;

   answer_type pending_answers [$];
   stim_row_type directed_rows [$];

   bit idle_en = 1'b1;
   bit hold_pending = 1'b0;
   int mismatch_count = 0;
   int stall_cycles = 0;
   int n_write = 0;
   int n_best = 0;
   int n_exact = 0;
   int n_ignored = 0;
   int n_checked = 0;
   int n_csr = 0;

   hierarchical_code_best_match_core i_dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_entry_count(csr_entry_count),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_entry_index(req_entry_index),
      .req_code_length(req_code_length),
      .req_code_digits(req_code_digits),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_found(rsp_found),
      .rsp_best_slot(rsp_best_slot),
      .rsp_best_length(rsp_best_length),
      .rsp_best_code(rsp_best_code),
      .rsp_distance(rsp_distance),
      .rsp_provided(rsp_provided)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // digit mask covering the first len digits
   function automatic logic [hcbm_pkg::CODE_W-1:0] keep_mask(input int len);
      logic [hcbm_pkg::CODE_W-1:0] m;
      m = '0;
      for (int i = 0; i < hcbm_pkg::MAX_DEPTH; i++)
         if (i < len) m[i*hcbm_pkg::DIGIT_BITS +: hcbm_pkg::DIGIT_BITS] = '1;
      return m;
   endfunction

   // zero when the entry is a prefix of the query, else the longer tail
   function automatic int code_distance(input logic [hcbm_pkg::CODE_W-1:0] qc,
                                        input int ql,
                                        input logic [hcbm_pkg::CODE_W-1:0] ec,
                                        input int el);
      int cp;
      int lim;
      cp = 0;
      lim = (ql < el) ? ql : el;
      while (cp < lim && qc[cp*hcbm_pkg::DIGIT_BITS +: hcbm_pkg::DIGIT_BITS] ==
                         ec[cp*hcbm_pkg::DIGIT_BITS +: hcbm_pkg::DIGIT_BITS])
         cp++;
      if (el == cp) return 0;
      return (el - cp > ql - cp) ? el - cp : ql - cp;
   endfunction

   // applies one request to the shadow table; returns 1 when a response is due
   function automatic bit predict_lookup(input logic [hcbm_pkg::FUNC_W-1:0] func,
                                         input logic [hcbm_pkg::SLOT_W-1:0] idx,
                                         input logic [hcbm_pkg::LEN_W-1:0] len_in,
                                         input logic [hcbm_pkg::CODE_W-1:0] dig_in,
                                         output answer_type ans);
      logic [hcbm_pkg::LEN_W-1:0] ql;
      logic [hcbm_pkg::CODE_W-1:0] qc;
      int n;
      int d;
      bit has;
      ans = '0;
      has = 1'b0;
      ql = (len_in > DEPTH_LEN) ? DEPTH_LEN : len_in;
      qc = dig_in & keep_mask(int'(ql));
      n = (int'(entry_count_reg) > TABLE_SIZE) ? TABLE_SIZE : int'(entry_count_reg);
      case (func)
         hcbm_pkg::FUNC_WRITE: begin
            slot_len[idx] = ql;
            slot_code[idx] = qc;
         end
         hcbm_pkg::FUNC_BEST: begin
            has = 1'b1;
            ans.distance = DEPTH_LEN;
            for (int i = 0; i < n; i++) begin
               d = code_distance(qc, int'(ql), slot_code[i], int'(slot_len[i]));
               if (!ans.found || d < int'(ans.distance)) begin
                  ans.found = 1'b1;
                  ans.distance = 4'(d);
                  ans.best_slot = 3'(i);
                  ans.best_length = slot_len[i];
                  ans.best_code = slot_code[i];
               end
            end
         end
         hcbm_pkg::FUNC_EXACT: begin
            has = 1'b1;
            for (int i = 0; i < n; i++)
               if (slot_len[i] == ql && slot_code[i] == qc) ans.provided = 1'b1;
         end
         default: has = 1'b0;
      endcase
      return has;
   endfunction

   // directed table builders
   function automatic void add_req(input logic [hcbm_pkg::FUNC_W-1:0] f,
                                   input logic [hcbm_pkg::SLOT_W-1:0] idx,
                                   input logic [hcbm_pkg::LEN_W-1:0] len,
                                   input logic [hcbm_pkg::CODE_W-1:0] dig);
      stim_row_type r;
      r = '0;
      r.func = f;
      r.idx = idx;
      r.len = len;
      r.digits = dig;
      directed_rows = {directed_rows, r};
   endfunction

   function automatic void add_typed(input logic [hcbm_pkg::FUNC_W-1:0] f,
                                     input logic [hcbm_pkg::LEN_W-1:0] len,
                                     input logic [hcbm_pkg::CODE_W-1:0] dig,
                                     input answer_type a);
      stim_row_type r;
      r = '0;
      r.func = f;
      r.len = len;
      r.digits = dig;
      r.typed = 1'b1;
      r.ans = a;
      directed_rows = {directed_rows, r};
   endfunction

   function automatic void add_csr(input logic [hcbm_pkg::LEN_W-1:0] v);
      stim_row_type r;
      r = '0;
      r.is_csr = 1'b1;
      r.csr_value = v;
      directed_rows = {directed_rows, r};
   endfunction

   // random request, mostly derived from a searched entry so prefixes overlap
   function automatic stim_row_type random_row();
      stim_row_type r;
      int pick;
      int n;
      int src;
      int len;
      int k;
      logic [hcbm_pkg::CODE_W-1:0] dig;
      r = '0;
      pick = $urandom_range(0, 99);
      r.func = (pick < 30) ? hcbm_pkg::FUNC_WRITE : (pick < 62) ? hcbm_pkg::FUNC_BEST :
               (pick < 92) ? hcbm_pkg::FUNC_EXACT : FUNC_UNUSED;
      r.idx = 3'($urandom_range(0, TABLE_SIZE - 1));
      n = (int'(entry_count_reg) > TABLE_SIZE) ? TABLE_SIZE : int'(entry_count_reg);
      src = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, TABLE_SIZE - 1);
      len = int'(slot_len[src]);
      dig = slot_code[src];
      case ($urandom_range(0, 5))
         0: begin
            // anything at all
            len = $urandom_range(0, 15);
            dig = $urandom();
         end
         1: ;
         2: begin
            // truncated entry
            if (len > 0) len = $urandom_range(0, len - 1);
         end
         3: begin
            // entry extended by a few digits
            k = $urandom_range(1, 3);
            while (k > 0 && len < hcbm_pkg::MAX_DEPTH) begin
               dig[len*hcbm_pkg::DIGIT_BITS +: hcbm_pkg::DIGIT_BITS] = 4'($urandom_range(0, 2));
               len++;
               k--;
            end
         end
         4: begin
            // one digit changed
            if (len > 0) begin
               k = $urandom_range(0, len - 1);
               dig[k*hcbm_pkg::DIGIT_BITS +: hcbm_pkg::DIGIT_BITS] = 4'($urandom_range(0, 3));
            end
         end
         default: begin
            // short alphabet so codes share prefixes
            len = $urandom_range(0, hcbm_pkg::MAX_DEPTH);
            dig = '0;
            for (int i = 0; i < len; i++)
               dig[i*hcbm_pkg::DIGIT_BITS +: hcbm_pkg::DIGIT_BITS] = 4'($urandom_range(0, 2));
         end
      endcase
      // junk past the length and overlong lengths
      if ($urandom_range(0, 3) == 0) dig = dig | ($urandom() & ~keep_mask(len));
      if (len == hcbm_pkg::MAX_DEPTH && $urandom_range(0, 3) == 0)
         len = $urandom_range(hcbm_pkg::MAX_DEPTH, 15);
      r.len = 4'(len);
      r.digits = dig;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [hcbm_pkg::CODE_W-1:0] got,
                                  input logic [hcbm_pkg::CODE_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
   endtask

   // drive one request and wait for its transaction
   task automatic send_req(input stim_row_type row);
      answer_type ans;
      bit has_ans;
      @(negedge clock);
      if (idle_en && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= row.func;
      req_entry_index <= row.idx;
      req_code_length <= row.len;
      req_code_digits <= row.digits;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      has_ans = predict_lookup(row.func, row.idx, row.len, row.digits, ans);
      if (has_ans) pending_answers = {pending_answers, (row.typed ? row.ans : ans)};
      case (row.func)
         hcbm_pkg::FUNC_WRITE: n_write++;
         hcbm_pkg::FUNC_BEST: n_best++;
         hcbm_pkg::FUNC_EXACT: n_exact++;
         default: n_ignored++;
      endcase
   endtask

   // entry_count write once the block has gone quiet
   task automatic write_entry_count(input logic [hcbm_pkg::LEN_W-1:0] v);
      @(negedge clock) req_valid <= 1'b0;
      while (pending_answers.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_entry_count <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      entry_count_reg = v;
      n_csr++;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // response side: random stalls plus one long hold-off on request
   initial begin : rsp_driver
      int gap_left;
      int hold_left;
      gap_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_ready <= 1'b0;
         end else if (idle_en && $urandom_range(0, 99) < 10) begin
            gap_left = $urandom_range(1, 18) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // response checker
   always @(posedge clock) begin : rsp_check
      answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected response", 32'(rsp_distance), '0);
         end else begin
            want = pending_answers.pop_front();
            n_checked++;
            if (rsp_found !== want.found)
               report_mismatch("found", 32'(rsp_found), 32'(want.found));
            if (rsp_best_slot !== want.best_slot)
               report_mismatch("best_slot", 32'(rsp_best_slot), 32'(want.best_slot));
            if (rsp_best_length !== want.best_length)
               report_mismatch("best_length", 32'(rsp_best_length), 32'(want.best_length));
            if (rsp_best_code !== want.best_code)
               report_mismatch("best_code", rsp_best_code, want.best_code);
            if (rsp_distance !== want.distance)
               report_mismatch("distance", 32'(rsp_distance), 32'(want.distance));
            if (rsp_provided !== want.provided)
               report_mismatch("provided", 32'(rsp_provided), 32'(want.provided));
         end
      end
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : main
      int phase_counts [8];
      int issued;
      stim_row_type r;
      phase_counts = '{8, 3, 15, 0, 1, 5, 9, 8};
      phase_counts[5] = $urandom_range(2, 7);

      // empty table right after reset
      add_typed(hcbm_pkg::FUNC_BEST, 4'd3, 32'h0000_0321,
                answer_type'({1'b0, 3'd0, 4'd0, 32'h0, DEPTH_LEN, 1'b0}));
      add_typed(hcbm_pkg::FUNC_EXACT, 4'd0, 32'h0, answer_type'('0));
      add_req(FUNC_UNUSED, 3'd7, 4'd15, 32'hFFFF_FFFF);
      // fill every slot: full depth, overlong, junk digits, root code
      add_req(hcbm_pkg::FUNC_WRITE, 3'd0, 4'd8, 32'h8765_4321);
      add_req(hcbm_pkg::FUNC_WRITE, 3'd1, 4'd15, 32'hFFFF_FFFF);
      add_req(hcbm_pkg::FUNC_WRITE, 3'd2, 4'd3, 32'hABCD_E123);
      add_req(hcbm_pkg::FUNC_WRITE, 3'd3, 4'd2, 32'h0000_0021);
      add_req(hcbm_pkg::FUNC_WRITE, 3'd4, 4'd5, 32'h0005_4321);
      add_req(hcbm_pkg::FUNC_WRITE, 3'd5, 4'd1, 32'h0000_0009);
      add_req(hcbm_pkg::FUNC_WRITE, 3'd6, 4'd4, 32'h0000_0000);
      add_req(hcbm_pkg::FUNC_WRITE, 3'd7, 4'd0, 32'hDEAD_BEEF);
      add_csr(4'd8);
      add_typed(hcbm_pkg::FUNC_BEST, 4'd8, 32'h8765_4321,
                answer_type'({1'b1, 3'd0, 4'd8, 32'h8765_4321, 4'd0, 1'b0}));
      add_typed(hcbm_pkg::FUNC_BEST, 4'd15, 32'hFFFF_FFFF,
                answer_type'({1'b1, 3'd1, 4'd8, 32'hFFFF_FFFF, 4'd0, 1'b0}));
      add_req(hcbm_pkg::FUNC_BEST, 3'd0, 4'd6, 32'h0065_4321);
      add_req(hcbm_pkg::FUNC_BEST, 3'd0, 4'd2, 32'h0000_0077);
      add_req(hcbm_pkg::FUNC_EXACT, 3'd0, 4'd3, 32'hFFFF_F123);
      add_req(hcbm_pkg::FUNC_EXACT, 3'd0, 4'd4, 32'h0000_0000);
      add_req(hcbm_pkg::FUNC_EXACT, 3'd0, 4'd7, 32'h0765_4321);
      // count above the table size
      add_csr(4'd15);
      add_req(hcbm_pkg::FUNC_BEST, 3'd0, 4'd0, 32'h0000_0000);
      add_req(hcbm_pkg::FUNC_EXACT, 3'd5, 4'd0, 32'h1234_5678);
      add_req(FUNC_UNUSED, 3'd0, 4'd0, 32'h0000_0000);
      add_csr(4'd1);
      add_req(hcbm_pkg::FUNC_BEST, 3'd0, 4'd1, 32'h0000_0005);
      add_typed(hcbm_pkg::FUNC_EXACT, 4'd8, 32'h8765_4321,
                answer_type'({1'b0, 3'd0, 4'd0, 32'h0, 4'd0, 1'b1}));
      add_csr(4'd0);
      add_typed(hcbm_pkg::FUNC_BEST, 4'd8, 32'h8765_4321,
                answer_type'({1'b0, 3'd0, 4'd0, 32'h0, DEPTH_LEN, 1'b0}));

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed part
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr)
            write_entry_count(directed_rows[i].csr_value);
         else
            send_req(directed_rows[i]);
      end

      // random phases, one entry_count setting each; phases 3, 6 and 7 run without stalls
      for (int ph = 0; ph < 8; ph++) begin
         idle_en = (ph != 3 && ph < 6);
         write_entry_count(4'(phase_counts[ph]));
         if (ph == 1) hold_pending = 1'b1;
         issued = 0;
         while (issued < PHASE_ITEMS) begin
            r = random_row();
            send_req(r);
            if (r.func != FUNC_UNUSED) issued++;
         end
      end

      // drain
      @(negedge clock) req_valid <= 1'b0;
      while (pending_answers.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d writes, %0d best-match and %0d exact-match queries, %0d ignored",
               n_write, n_best, n_exact, n_ignored);
      $display("checked %0d responses over %0d entry_count writes, %0d mismatches",
               n_checked, n_csr, mismatch_count);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/hcbm_pkg.sv
rtl/hcbm_cell.sv
rtl/hierarchical_code_best_match_core.sv
dv/tb.sv
